### rtl/klx_pkg.sv
// ----------------------------------------------------------------------------
// klx_pkg - shared types and constants of the keyword/ident/number lexer
// Token kinds, token record, character codes and packed keyword spellings.
// ----------------------------------------------------------------------------
package klx_pkg;

  localparam int TEXT_BYTES_DEF = 8;
  localparam int TEXT_W         = 64;

  typedef enum logic [3:0] {
    KIND_EXIT  = 4'd0,
    KIND_LET   = 4'd1,
    KIND_IDENT = 4'd2,
    KIND_INT   = 4'd3,
    KIND_OPEN  = 4'd4,
    KIND_CLOSE = 4'd5,
    KIND_SEMI  = 4'd6,
    KIND_EQ    = 4'd7,
    KIND_PLUS  = 4'd8,
    KIND_ERROR = 4'd9
  } kind_t;

  // "exit" and "let", first byte in the low bits
  localparam logic [31:0] WORD_EXIT = 32'h7469_7865;
  localparam logic [31:0] WORD_LET  = 32'h0074_656C;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  typedef struct packed {
    kind_t             kind;
    logic [TEXT_W-1:0] text;
    logic [7:0]        length;
    logic              trunc;
  } token_t;

  // what one byte produces: up to two tokens, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_res_t;

endpackage

### rtl/klx_step.sv
// ----------------------------------------------------------------------------
// klx_step - lexer state and per-byte scan logic
// Holds mode, text buffer and count; classifies one byte and forms its tokens.
// ----------------------------------------------------------------------------
module klx_step
  import klx_pkg::*;
#(
  parameter int TEXT_BYTES = TEXT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] char_byte,
  input  logic       end_of_text,
  output step_res_t  res
);

  localparam int BUF_W = 8 * TEXT_BYTES;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_DISCARD
  } mode_t;

  mode_t            mode, mode_next, mode_a;
  logic [BUF_W-1:0] text_buf, text_buf_next, buf_a;
  logic [7:0]       text_count, text_count_next, cnt_a;
  logic             is_alpha, is_digit, is_space, is_punct, cont;
  kind_t            punct_kind;
  logic [1:0]       n;

  assign is_alpha = (char_byte >= CH_UA && char_byte <= CH_UZ) ||
                    (char_byte >= CH_LA && char_byte <= CH_LZ);
  assign is_digit = char_byte >= CH_D0 && char_byte <= CH_D9;
  assign is_space = char_byte == CH_SPACE || (char_byte >= CH_TAB && char_byte <= CH_CR);

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_OPEN;
    case (char_byte)
      CH_OPEN:  punct_kind = KIND_OPEN;
      CH_CLOSE: punct_kind = KIND_CLOSE;
      CH_SEMI:  punct_kind = KIND_SEMI;
      CH_EQ:    punct_kind = KIND_EQ;
      CH_PLUS:  punct_kind = KIND_PLUS;
      default:  is_punct = 1'b0;
    endcase
  end

  function automatic token_t plain_tok(kind_t k);
    return '{kind: k, text: '0, length: '0, trunc: 1'b0};
  endfunction

  function automatic token_t run_tok(mode_t m, logic [BUF_W-1:0] b, logic [7:0] c);
    logic  tr;
    kind_t k;
    tr = c > 8'(TEXT_BYTES);
    k  = (m == MODE_NUM) ? KIND_INT : KIND_IDENT;
    if (m == MODE_IDENT && !tr && c == 8'd4 && b == BUF_W'(WORD_EXIT)) k = KIND_EXIT;
    else if (m == MODE_IDENT && !tr && c == 8'd3 && b == BUF_W'(WORD_LET)) k = KIND_LET;
    if (k == KIND_EXIT || k == KIND_LET) return plain_tok(k);
    return '{kind: k, text: TEXT_W'(b), length: c, trunc: tr};
  endfunction

  function automatic logic [BUF_W-1:0] append(logic [BUF_W-1:0] b, logic [7:0] c,
                                              logic [7:0] ch);
    logic [BUF_W-1:0] r;
    r = b;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      if (c == 8'(i)) r[i*8 +: 8] = ch;
    end
    return r;
  endfunction

  always_comb begin
    res             = '0;
    n               = 2'd0;
    mode_a          = mode;
    buf_a           = text_buf;
    cnt_a           = text_count;
    mode_next       = mode;
    text_buf_next   = text_buf;
    text_count_next = text_count;
    cont            = (mode == MODE_IDENT && (is_alpha || is_digit)) ||
                      (mode == MODE_NUM && is_digit);
    if (mode == MODE_DISCARD) begin
      if (end_of_text) begin
        mode_next       = MODE_IDLE;
        text_buf_next   = '0;
        text_count_next = '0;
      end
    end else begin
      if (cont) begin
        buf_a = append(text_buf, text_count, char_byte);
        cnt_a = (text_count == 8'hFF) ? text_count : text_count + 8'd1;
      end else begin
        if (mode == MODE_IDENT || mode == MODE_NUM) begin
          res.tok0 = run_tok(mode, text_buf, text_count);
          n        = 2'd1;
        end
        mode_a = MODE_IDLE;
        buf_a  = '0;
        cnt_a  = '0;
        if (is_alpha || is_digit) begin
          mode_a = is_alpha ? MODE_IDENT : MODE_NUM;
          buf_a  = BUF_W'(char_byte);
          cnt_a  = 8'd1;
        end else if (is_punct || !is_space) begin
          if (n == 2'd0) res.tok0 = plain_tok(is_punct ? punct_kind : KIND_ERROR);
          else           res.tok1 = plain_tok(is_punct ? punct_kind : KIND_ERROR);
          n = n + 2'd1;
          if (!is_punct) mode_a = MODE_DISCARD;
        end
      end
      if (end_of_text) begin
        // final byte flushes whatever run is still open
        if (mode_a == MODE_IDENT || mode_a == MODE_NUM) begin
          if (n == 2'd0) res.tok0 = run_tok(mode_a, buf_a, cnt_a);
          else           res.tok1 = run_tok(mode_a, buf_a, cnt_a);
          n = n + 2'd1;
        end
        mode_next       = MODE_IDLE;
        text_buf_next   = '0;
        text_count_next = '0;
      end else begin
        mode_next       = mode_a;
        text_buf_next   = buf_a;
        text_count_next = cnt_a;
      end
    end
    res.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      text_buf   <= '0;
      text_count <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      text_buf   <= text_buf_next;
      text_count <= text_count_next;
    end
  end

endmodule

### rtl/klx_out.sv
// ----------------------------------------------------------------------------
// klx_out - token result register
// Holds the one or two tokens of a byte and hands them out one word at a time.
// ----------------------------------------------------------------------------
module klx_out
  import klx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  step_res_t   res,
  output logic        ready,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [63:0] token_text,
  output logic [7:0]  text_length,
  output logic        text_truncated,
  output logic        last_of_run
);

  logic   valid, sel, two;
  token_t tok0, tok1, cur;
  logic   tok_acc, at_last;

  assign tok_acc = valid && !token_stall;
  assign at_last = !two || sel;
  assign ready   = !valid || (tok_acc && at_last);
  assign cur     = sel ? tok1 : tok0;

  assign token_valid    = valid;
  assign token_kind     = cur.kind;
  assign token_text     = cur.text;
  assign text_length    = cur.length;
  assign text_truncated = cur.trunc;
  assign last_of_run    = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
      two   <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      sel   <= 1'b0;
      two   <= res.count == 2'd2;
    end else if (tok_acc) begin
      if (!at_last) begin
        sel <= 1'b1;
      end else begin
        valid <= 1'b0;
        sel   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok0 <= res.tok0;
      tok1 <= res.tok1;
    end
  end

  // second slot only shown for a live pair
  a_sel_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> (valid && two)) else $error("second token selected without a pair");

  // a new byte never overwrites tokens still owed
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    load |-> ready) else $error("token register loaded while busy");

  // taking the first of a pair leads straight to the second
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (tok_acc && two && !sel) |=> (valid && sel)) else $error("second token of pair lost");

endmodule

### rtl/keyword_ident_number_lexer.sv
// ----------------------------------------------------------------------------
// keyword_ident_number_lexer - byte-serial lexer for a small language
// Scans source bytes into keyword, identifier, literal and punctuation tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_stall): one source byte per word in
//   char_byte, end_of_text set on the final byte of the source.
//   Token channel (token_valid/token_stall): one token per word; last_of_run
//   marks the final token caused by a given byte.
//   Path: a byte in the input register is scanned there; its tokens load into
//   the token register as it leaves. Throughput: one byte per cycle while
//   token_stall is low; a byte that yields two tokens (a run closed by
//   punctuation, an error, or a final byte) holds the token register for two
//   words; a following byte that yields tokens waits in the input register.
//   The lexer state (mode, buffer, count) is a registered loop updated only
//   when a byte leaves the input register. Stall: token_stall holds the token
//   register; once it is busy, a byte that yields tokens holds in the input
//   register and byte_stall rises. Nothing is dropped.
//   Reset (rst, synchronous): lexer idle, buffer empty, both registers empty.
//   An error byte emits an error token and further bytes are dropped without
//   output up to and including the one flagged end_of_text.
// ----------------------------------------------------------------------------
module keyword_ident_number_lexer
  import klx_pkg::*;
#(
  parameter int TEXT_BYTES = TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [3:0]  token_kind,
  output logic [63:0] token_text,
  output logic [7:0]  text_length,
  output logic        text_truncated,
  output logic        last_of_run
);

  // input register
  logic       in_full;
  logic [7:0] in_char;
  logic       in_last;

  step_res_t res;
  logic      out_ready, advance, load;

  // a byte with no tokens (whitespace, run continuation, discard) moves on
  // even when the token register is busy
  assign advance    = in_full && (res.count == 2'd0 || out_ready);
  assign load       = advance && res.count != 2'd0;
  assign byte_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (byte_valid && !byte_stall) || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_char <= char_byte;
      in_last <= end_of_text;
    end
  end

  klx_step #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .char_byte  (in_char),
    .end_of_text(in_last),
    .res        (res)
  );

  klx_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .res           (res),
    .ready         (out_ready),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .token_text    (token_text),
    .text_length   (text_length),
    .text_truncated(text_truncated),
    .last_of_run   (last_of_run)
  );

endmodule

### test/tb_keyword_ident_number_lexer.sv
// ----------------------------------------------------------------------------
// tb_keyword_ident_number_lexer - self-checking bench for the byte lexer
// Feeds source bytes through the byte channel and predicts every token from a
// local scanner model. Each token word is checked field by field against the
// oldest prediction. Random idle and stall cycles are applied on both sides.
// ----------------------------------------------------------------------------
module tb_keyword_ident_number_lexer;
  import klx_pkg::*;

  localparam int KEEP = TEXT_BYTES_DEF;  // bytes of run text kept in a token
  localparam int TAIL_CYCLES = 20;       // settle time after the last token
  localparam int MAX_LINES = 40;         // cap on printed mismatch lines
  localparam int TARGET_WORDS = 1800;    // random words not lost to discard mode

  typedef enum logic [1:0] {
    SCAN_IDLE    = 2'd0,
    SCAN_IDENT   = 2'd1,
    SCAN_NUM     = 2'd2,
    SCAN_DISCARD = 2'd3
  } scan_mode_t;

  // one source byte waiting to be driven
  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         gap;    // idle cycles before this word goes out
    bit         drain;  // hold this word until every token has come back
  } src_word_t;

  // one predicted token
  typedef struct {
    kind_t       kind;
    logic [63:0] text;
    logic [7:0]  length;
    logic        trunc;
    logic        last;
  } tok_exp_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  char_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [63:0] token_text;
  logic [7:0]  text_length;
  logic        text_truncated;
  logic        last_of_run;

  keyword_ident_number_lexer dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .char_byte      (char_byte),
    .end_of_text    (end_of_text),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_kind     (token_kind),
    .token_text     (token_text),
    .text_length    (text_length),
    .text_truncated (text_truncated),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

  src_word_t  src_q[$];      // bytes still to be driven
  tok_exp_t   want_tokens[$]; // tokens predicted but not yet seen
  tok_exp_t   step_toks[$];   // tokens of the byte being scanned
  int         err_count = 0;
  int         tokens_seen = 0;

  // scanner model state
  scan_mode_t scan_mode;
  logic [63:0] run_text;
  logic [7:0]  run_len;

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  // only HT..CR and space are whitespace
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_mark(logic [7:0] c);
    return c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI || c == CH_EQ || c == CH_PLUS;
  endfunction

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------
  function automatic void clear_scan();
    scan_mode = SCAN_IDLE;
    run_text  = '0;
    run_len   = '0;
  endfunction

  // text past KEEP bytes is dropped; the count still runs up to 255
  function automatic void grow_run(logic [7:0] c);
    if (run_len < KEEP)
      run_text[8*run_len +: 8] = c;
    if (run_len != 8'd255)
      run_len++;
  endfunction

  function automatic void stage_tok(tok_exp_t t);
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void add_simple(kind_t k);
    tok_exp_t t;
    t.kind   = k;
    t.text   = '0;
    t.length = '0;
    t.trunc  = 1'b0;
    t.last   = 1'b0;
    stage_tok(t);
  endfunction

  // emit a pending identifier or literal, keywords carry no text
  function automatic void close_run();
    tok_exp_t t;
    logic     cut;
    cut      = run_len > KEEP;
    t.kind   = KIND_INT;
    t.text   = run_text;
    t.length = run_len;
    t.trunc  = cut;
    t.last   = 1'b0;
    if (scan_mode == SCAN_IDENT) begin
      t.kind = KIND_IDENT;
      if (!cut && run_len == 8'd4 && run_text == {32'd0, WORD_EXIT}) begin
        add_simple(KIND_EXIT);
        clear_scan();
        return;
      end
      if (!cut && run_len == 8'd3 && run_text == {32'd0, WORD_LET}) begin
        add_simple(KIND_LET);
        clear_scan();
        return;
      end
    end else if (scan_mode != SCAN_NUM) begin
      return;
    end
    stage_tok(t);
    clear_scan();
  endfunction

  // scan one accepted byte and queue the tokens it yields
  function automatic void scan_byte(logic [7:0] c, logic eot);
    tok_exp_t t;
    step_toks.delete();
    if (scan_mode == SCAN_DISCARD) begin
      if (eot)
        clear_scan();
      return;
    end
    if (scan_mode == SCAN_IDENT && (is_letter(c) || is_digit(c))) begin
      grow_run(c);
    end else if (scan_mode == SCAN_NUM && is_digit(c)) begin
      grow_run(c);
    end else begin
      close_run();
      if (is_letter(c)) begin
        scan_mode = SCAN_IDENT;
        grow_run(c);
      end else if (is_digit(c)) begin
        scan_mode = SCAN_NUM;
        grow_run(c);
      end else if (c == CH_OPEN) begin
        add_simple(KIND_OPEN);
      end else if (c == CH_CLOSE) begin
        add_simple(KIND_CLOSE);
      end else if (c == CH_SEMI) begin
        add_simple(KIND_SEMI);
      end else if (c == CH_EQ) begin
        add_simple(KIND_EQ);
      end else if (c == CH_PLUS) begin
        add_simple(KIND_PLUS);
      end else if (!is_blank(c)) begin
        add_simple(KIND_ERROR);
        scan_mode = SCAN_DISCARD;
      end
    end
    if (eot) begin
      close_run();
      clear_scan();
    end
    // last_of_run goes on the final token of this byte
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      want_tokens.insert(want_tokens.size(), t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  bit gen_quiet = 0;   // sentence sent back to back
  bit gen_dead = 0;    // rest of the sentence falls in discard mode
  bit next_drain = 0;
  int live_words = 0;
  logic [7:0] sent[$];

  // at least half the draws give no wait, and a quiet draw never waits
  function automatic int draw_gap(bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 9);
    if (r < 5)
      return 0;
    if (r < 8)
      return $urandom_range(1, 3);
    return $urandom_range(0, 19);
  endfunction

  function automatic void push_word(logic [7:0] c, logic eot);
    src_word_t w;
    w.ch    = c;
    w.eot   = eot;
    w.gap   = draw_gap(gen_quiet);
    w.drain = next_drain;
    next_drain = 0;
    src_q.insert(src_q.size(), w);
    if (!gen_dead) begin
      live_words++;
      if (!is_letter(c) && !is_digit(c) && !is_blank(c) && !is_mark(c))
        gen_dead = 1;
    end
    if (eot)
      gen_dead = 0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    sent.insert(sent.size(), c);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++)
      put_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CH_UA : CH_LA;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_D0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 6);
    return (r < 5) ? CH_TAB + 8'(r) : CH_SPACE;
  endfunction

  function automatic void add_ident(int n);
    put_char(rand_letter());
    for (int i = 1; i < n; i++)
      put_char($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
  endfunction

  function automatic void add_number(int n);
    for (int i = 0; i < n; i++)
      put_char(rand_digit());
  endfunction

  function automatic int run_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(KEEP + 1, KEEP + 6)
                                       : $urandom_range(1, KEEP);
  endfunction

  // one source text: a handful of tokens, end_of_text on its final byte
  function automatic void add_sentence(int idx);
    sent.delete();
    gen_quiet = ($urandom_range(0, 3) == 0);
    if (idx == 5) begin
      add_ident($urandom_range(257, 300));  // count saturates at 255
    end else if (idx == 20) begin
      add_number($urandom_range(256, 270));
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 13))
          0: add_str("exit");
          1: add_str("let");
          2: begin
            case ($urandom_range(0, 7))
              0: add_str("exi");
              1: add_str("exits");
              2: add_str("Exit");
              3: add_str("le");
              4: add_str("lets");
              5: add_str("LET");
              6: add_str("exit1");
              default: add_str("let0");
            endcase
          end
          3, 4, 5: add_ident(run_size());
          6, 7: add_number(run_size());
          8, 9, 10: begin
            case ($urandom_range(0, 4))
              0: put_char(CH_OPEN);
              1: put_char(CH_CLOSE);
              2: put_char(CH_SEMI);
              3: put_char(CH_EQ);
              default: put_char(CH_PLUS);
            endcase
          end
          11, 12: repeat ($urandom_range(1, 3)) put_char(rand_blank());
          default: begin
            // noise: a blank, or now and then any byte value, usually an error that kills the sentence
            if ($urandom_range(0, 2) == 0)
              put_char(8'($urandom_range(0, 255)));
            else
              put_char(rand_blank());
          end
        endcase
        if ($urandom_range(0, 1) == 0)
          put_char(rand_blank());
      end
    end
    for (int i = 0; i < sent.size(); i++)
      push_word(sent[i], i == sent.size() - 1);
  endfunction

  function automatic void add_str_direct(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++)
      push_word(s[i], eot_last && i == s.len() - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(string field, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_LINES)
      $display("MISMATCH token %0d %s: got %h want %h", tokens_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: presents queued words, predicts tokens on every accept
  // ---------------------------------------------------------------------------
  bit        tx_loaded;
  int        tx_idle;
  src_word_t tx_word;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      char_byte   <= 8'd0;
      end_of_text <= 1'b0;
      tx_loaded = 0;
      tx_idle   = 0;
      clear_scan();
    end else begin
      if (byte_valid && !byte_stall)
        scan_byte(char_byte, end_of_text);
      // a stalled word holds; otherwise the channel is free to move on
      if (!byte_valid || !byte_stall) begin
        if (!tx_loaded && src_q.size() > 0) begin
          tx_idle   = src_q[0].gap;
          tx_loaded = 1;
        end
        if (tx_loaded && tx_idle == 0 &&
            !(src_q[0].drain && want_tokens.size() != 0)) begin
          tx_word = src_q.pop_front();
          byte_valid  <= 1'b1;
          char_byte   <= tx_word.ch;
          end_of_text <= tx_word.eot;
          tx_loaded = 0;
        end else begin
          byte_valid <= 1'b0;
          if (tx_loaded && tx_idle > 0)
            tx_idle--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token monitor: checks each accepted word, draws the next stall stretch
  // ---------------------------------------------------------------------------
  int       rx_hold;
  bit       rx_quiet;
  tok_exp_t rx_want;

  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
      rx_hold  = 0;
      rx_quiet = 0;
    end else begin
      if (token_valid && !token_stall) begin
        if (want_tokens.size() == 0) begin
          log_mismatch("unexpected word", {60'd0, token_kind}, '0);
        end else begin
          rx_want = want_tokens.pop_front();
          if (token_kind !== rx_want.kind)
            log_mismatch("token_kind", 64'(token_kind), 64'(rx_want.kind));
          if (token_text !== rx_want.text)
            log_mismatch("token_text", token_text, rx_want.text);
          if (text_length !== rx_want.length)
            log_mismatch("text_length", 64'(text_length), 64'(rx_want.length));
          if (text_truncated !== rx_want.trunc)
            log_mismatch("text_truncated", 64'(text_truncated), 64'(rx_want.trunc));
          if (last_of_run !== rx_want.last)
            log_mismatch("last_of_run", 64'(last_of_run), 64'(rx_want.last));
        end
        tokens_seen++;
        // flip between back-to-back and stalling stretches now and then
        if ($urandom_range(0, 63) == 0)
          rx_quiet = !rx_quiet;
        rx_hold = draw_gap(rx_quiet);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      token_stall <= (rx_hold > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int idx;
    // directed: keywords, every punctuation, whitespace kinds, a run closed
    // by punctuation, and a final byte that closes a run
    add_str_direct("exit let\tx=(12)+y;", 1'b1);
    // identifier closed by an error byte (two tokens), then discard to the end
    push_word("b", 1'b0);
    push_word(8'hFF, 1'b0);
    push_word("q", 1'b1);
    // error byte that is also the final byte
    push_word(8'h00, 1'b1);
    // digit on the final byte, carriage return skipped
    push_word(CH_CR, 1'b0);
    push_word("7", 1'b1);

    // random part; the first sentence waits for a full drain
    live_words = 0;
    next_drain = 1;
    idx = 0;
    while (live_words < TARGET_WORDS) begin
      if (idx % 25 == 24)
        next_drain = 1;
      add_sentence(idx);
      idx++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so the driver's updates have settled
    while (src_q.size() != 0 || byte_valid || rst)
      @(negedge clk);
    while (want_tokens.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/klx_pkg.sv
rtl/klx_step.sv
rtl/klx_out.sv
rtl/keyword_ident_number_lexer.sv
test/tb_keyword_ident_number_lexer.sv
